/* hw/rtl/whc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whc_pkg: shared definitions for the wrapping counter history
// Widths, operation and direction codes, reset values, the controller state
// type and the control word that drives the row of history cells.
// ----------------------------------------------------------------------------
package whc_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int DIR_W     = 2;
    localparam int OP_W      = 2;
    localparam int SPAN_W    = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_INS_ABS = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_REL = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_NONE     = 2'd2;

    localparam logic [SPAN_W-1:0] MIN_SPAN = 6'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MAX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MIN = 1'd1;

    localparam logic [VAL_W-1:0] WRAP_MAX_RST = 32'd65535;
    localparam logic [VAL_W-1:0] WRAP_MIN_RST = 32'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WRAP,
        S_WALK,
        S_QOUT
    } state_t;

    // Control word shared by all cells of the history row.
    typedef struct packed {
        logic shift;    // take the newer neighbor, the newest cell loads a new reading
        logic rotate;   // take the older neighbor, the oldest cell takes the newest
    } cell_ctrl_t;

endpackage

/* hw/rtl/whc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whc_if: valid/ready channels of the wrapping counter history
// One interface for request words and one for response words.
// ----------------------------------------------------------------------------
interface whc_req_if;
    logic                          valid;
    logic                          ready;
    logic [whc_pkg::OP_W-1:0]      opcode;
    logic [whc_pkg::DIR_W-1:0]     direction;
    logic signed [whc_pkg::VAL_W-1:0] sample;
    logic [whc_pkg::SPAN_W-1:0]    span;

    modport source (output valid, opcode, direction, sample, span, input ready);
    modport sink   (input valid, opcode, direction, sample, span, output ready);
endinterface

interface whc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic signed [whc_pkg::VAL_W-1:0] current_value;
    logic signed [whc_pkg::VAL_W-1:0] rel_change;
    logic                          status;

    modport source (output valid, current_value, rel_change, status, input ready);
    modport sink   (input valid, current_value, rel_change, status, output ready);
endinterface

/* hw/rtl/whc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whc_cell: one entry of the reading history
// Holds a value and a direction; loads from the newer neighbor on a shift and
// from the older neighbor on a rotate.
// ----------------------------------------------------------------------------
module whc_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  whc_pkg::cell_ctrl_t          ctrl,
    input  logic [whc_pkg::VAL_W-1:0]    shift_val,
    input  logic [whc_pkg::DIR_W-1:0]    shift_dir,
    input  logic [whc_pkg::VAL_W-1:0]    rot_val,
    input  logic [whc_pkg::DIR_W-1:0]    rot_dir,
    output logic [whc_pkg::VAL_W-1:0]    val,
    output logic [whc_pkg::DIR_W-1:0]    dir
);

    logic [whc_pkg::VAL_W-1:0] val_reg;
    logic [whc_pkg::DIR_W-1:0] dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            dir_reg <= whc_pkg::DIR_NONE;
        end
        else if (ctrl.shift)
        begin
            val_reg <= shift_val;
            dir_reg <= shift_dir;
        end
        else if (ctrl.rotate)
        begin
            val_reg <= rot_val;
            dir_reg <= rot_dir;
        end
    end

    assign val = val_reg;
    assign dir = dir_reg;

endmodule

/* hw/rtl/whc_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whc_walk: neighbor difference and running sum
// Forms the wrap-aware difference of the pair at the newest end of the row,
// registers it, and adds it into the accumulator in the following cycle.
// ----------------------------------------------------------------------------
module whc_walk (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         en,
    input  logic [whc_pkg::VAL_W-1:0]    older_val,
    input  logic [whc_pkg::VAL_W-1:0]    newer_val,
    input  logic [whc_pkg::DIR_W-1:0]    newer_dir,
    input  logic [whc_pkg::VAL_W-1:0]    range,
    output logic [whc_pkg::VAL_W-1:0]    acc
);

    logic [whc_pkg::VAL_W-1:0] base;
    logic [whc_pkg::VAL_W-1:0] diff_next;
    logic [whc_pkg::VAL_W-1:0] diff_reg;
    logic                      diff_vld_reg;
    logic [whc_pkg::VAL_W-1:0] acc_reg;

    // Crossing the wrap point adds or removes one full range (max - min).
    always_comb
    begin
        base = newer_val - older_val;
        case (newer_dir)
            whc_pkg::DIR_FORWARD:
                diff_next = ($signed(newer_val) >= $signed(older_val)) ? base : base + range;
            whc_pkg::DIR_BACKWARD:
                diff_next = ($signed(newer_val) <= $signed(older_val)) ? base : base - range;
            default:
                diff_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else if (clear)
        begin
            diff_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            diff_vld_reg <= en;
            if (diff_vld_reg)
            begin
                acc_reg <= acc_reg + diff_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    assign acc = acc_reg;

endmodule

/* hw/rtl/wrapping_counter_history.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapping_counter_history: history of counter readings with wrap-aware sums
// Keeps the last DEPTH readings (value and direction) in a row of cells,
// inserts absolute or relative readings and sums the wrap-aware changes over
// the newest span readings on request.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake          Word contents
//  --------  ----  -----------------  -----------------------------------------
//  req       in    valid / ready      opcode, direction, sample, span
//  rsp       out   valid / ready      current_value, rel_change, status
//  cfg       in    cfg_we (no ready)  cfg_index, cfg_data (wrap_max, wrap_min)
//
//  An absolute insert, an unused opcode and a query with a bad span load their
//  response from the EXEC state, a relative insert passes through WRAP first,
//  and a query through WALK and then QOUT. The walk rotates the history row
//  one place per cycle through the single difference unit, a full turn so
//  that the row ends in its original order.
//  Reset clears the history to zero values with direction none and loads the
//  wrap registers with their default values; no clearing pass is needed.
//  The response register parts the two sides: a new request word is taken
//  while a finished response waits; work stalls only when it must deliver a
//  response and the previous one has not yet been taken.
//
module wrapping_counter_history #(
    parameter int DEPTH = whc_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    whc_req_if.sink                           req,
    whc_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [whc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [whc_pkg::VAL_W-1:0]         cfg_data
);

    localparam int CW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int SW = whc_pkg::SPAN_W + 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_SPAN = SW'(DEPTH);

    // Configuration registers.
    logic [whc_pkg::VAL_W-1:0] wrap_max_reg;
    logic [whc_pkg::VAL_W-1:0] wrap_min_reg;
    logic [whc_pkg::VAL_W-1:0] range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_max_reg <= whc_pkg::WRAP_MAX_RST;
            wrap_min_reg <= whc_pkg::WRAP_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                whc_pkg::CFG_WRAP_MAX: wrap_max_reg <= cfg_data;
                whc_pkg::CFG_WRAP_MIN: wrap_min_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Both wrap corrections reduce to adding or removing (max - min).
    assign range = wrap_max_reg - wrap_min_reg;

    // Controller state and the latched request word.
    whc_pkg::state_t               state_reg, state_next;
    logic [whc_pkg::OP_W-1:0]      op_reg;
    logic [whc_pkg::DIR_W-1:0]     dir_reg;
    logic [whc_pkg::VAL_W-1:0]     sample_reg;
    logic [whc_pkg::SPAN_W-1:0]    span_reg;
    logic [whc_pkg::VAL_W-1:0]     sum_reg;
    logic [CW-1:0]                 step_reg;

    // Response register.
    logic                          rsp_valid_reg;
    logic [whc_pkg::VAL_W-1:0]     cur_reg, cur_next;
    logic [whc_pkg::VAL_W-1:0]     rel_reg, rel_next;
    logic                          status_reg, status_next;

    // History row.
    logic [whc_pkg::VAL_W-1:0]     cell_val [DEPTH];
    logic [whc_pkg::DIR_W-1:0]     cell_dir [DEPTH];
    whc_pkg::cell_ctrl_t           ctrl;
    logic [whc_pkg::VAL_W-1:0]     new_val;
    logic [whc_pkg::VAL_W-1:0]     newest;
    logic [whc_pkg::VAL_W-1:0]     wrapped;
    logic [whc_pkg::VAL_W-1:0]     acc;

    logic slot_free;
    logic emit;
    logic span_bad;
    logic walk_clear;
    logic walk_en;

    assign newest    = cell_val[DEPTH-1];
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign span_bad  = (span_reg < whc_pkg::MIN_SPAN) || ({1'b0, span_reg} > DEPTH_SPAN);

    // Single wrap of a relative insert: above max drops one range, below min
    // adds one range.
    always_comb
    begin
        if ($signed(sum_reg) > $signed(wrap_max_reg))
        begin
            wrapped = sum_reg - range;
        end
        else if ($signed(sum_reg) < $signed(wrap_min_reg))
        begin
            wrapped = sum_reg + range;
        end
        else
        begin
            wrapped = sum_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        emit        = 1'b0;
        cur_next    = newest;
        rel_next    = '0;
        status_next = 1'b0;
        new_val     = sample_reg;
        walk_clear  = 1'b0;
        walk_en     = 1'b0;
        req.ready   = 1'b0;
        case (state_reg)
            whc_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = whc_pkg::S_EXEC;
                end
            end
            whc_pkg::S_EXEC:
            begin
                case (op_reg)
                    whc_pkg::OP_INS_ABS:
                    begin
                        if (slot_free)
                        begin
                            ctrl.shift = 1'b1;
                            emit       = 1'b1;
                            cur_next   = sample_reg;
                            state_next = whc_pkg::S_IDLE;
                        end
                    end
                    whc_pkg::OP_INS_REL:
                    begin
                        state_next = whc_pkg::S_WRAP;
                    end
                    whc_pkg::OP_QUERY:
                    begin
                        if (span_bad)
                        begin
                            if (slot_free)
                            begin
                                emit        = 1'b1;
                                status_next = 1'b1;
                                state_next  = whc_pkg::S_IDLE;
                            end
                        end
                        else
                        begin
                            walk_clear = 1'b1;
                            state_next = whc_pkg::S_WALK;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = whc_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            whc_pkg::S_WRAP:
            begin
                new_val = wrapped;
                if (slot_free)
                begin
                    ctrl.shift = 1'b1;
                    emit       = 1'b1;
                    cur_next   = wrapped;
                    state_next = whc_pkg::S_IDLE;
                end
            end
            whc_pkg::S_WALK:
            begin
                // Step k looks at the pair k places back from the newest end.
                ctrl.rotate = 1'b1;
                walk_en     = ({1'b0, SW'(step_reg)} + 1'b1) < {1'b0, SW'(span_reg)};
                if (step_reg == LAST_STEP)
                begin
                    state_next = whc_pkg::S_QOUT;
                end
            end
            whc_pkg::S_QOUT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    rel_next   = acc;
                    state_next = whc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = whc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= whc_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == whc_pkg::S_WALK)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg     <= req.opcode;
            dir_reg    <= req.direction;
            sample_reg <= req.sample;
            span_reg   <= req.span;
        end
        if (state_reg == whc_pkg::S_EXEC)
        begin
            sum_reg <= newest + sample_reg;
        end
        if (emit)
        begin
            cur_reg    <= cur_next;
            rel_reg    <= rel_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.current_value = cur_reg;
    assign rsp.rel_change    = rel_reg;
    assign rsp.status        = status_reg;

    // Row of cells: shifts move toward the oldest end, rotations toward the
    // newest end with the newest entry wrapping around to the oldest place.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [whc_pkg::VAL_W-1:0] sh_val;
        logic [whc_pkg::DIR_W-1:0] sh_dir;
        logic [whc_pkg::VAL_W-1:0] ro_val;
        logic [whc_pkg::DIR_W-1:0] ro_dir;

        if (i == DEPTH - 1)
        begin : g_newest
            assign sh_val = new_val;
            assign sh_dir = dir_reg;
        end
        else
        begin : g_inner
            assign sh_val = cell_val[i+1];
            assign sh_dir = cell_dir[i+1];
        end

        if (i == 0)
        begin : g_oldest
            assign ro_val = cell_val[DEPTH-1];
            assign ro_dir = cell_dir[DEPTH-1];
        end
        else
        begin : g_rest
            assign ro_val = cell_val[i-1];
            assign ro_dir = cell_dir[i-1];
        end

        whc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .shift_val (sh_val),
            .shift_dir (sh_dir),
            .rot_val   (ro_val),
            .rot_dir   (ro_dir),
            .val       (cell_val[i]),
            .dir       (cell_dir[i])
        );
    end

    whc_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (walk_clear),
        .en        (walk_en),
        .older_val (cell_val[DEPTH-2]),
        .newer_val (cell_val[DEPTH-1]),
        .newer_dir (cell_dir[DEPTH-1]),
        .range     (range),
        .acc       (acc)
    );

    // A shift and a rotation of the row never coincide.
    a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.shift && ctrl.rotate))
        else $error("history row shifted and rotated in the same cycle");

    // A query result is reported only after a full turn of the row.
    a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == whc_pkg::S_QOUT && $past(state_reg) == whc_pkg::S_WALK)
        |-> $past(step_reg) == LAST_STEP)
        else $error("query walk ended before a full rotation");

    // An error status comes only from a query with a bad span.
    a_status_src: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && status_next) |-> (op_reg == whc_pkg::OP_QUERY && span_bad))
        else $error("error status raised outside a bad-span query");

    // The response register only fills when the controller delivers a word.
    a_rsp_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(emit))
        else $error("response word appeared without a delivery");

endmodule
